@@ rtl/scba_pkg.sv @@
`default_nettype none

package scba_pkg;

  // Pool geometry.
  localparam int SLICES     = 64;
  localparam int SLICE_BITS = 10;
  localparam int CLASSES    = SLICE_BITS;
  localparam int SLICE_BYTES = 1 << SLICE_BITS;
  localparam int POOL_BYTES  = SLICES << SLICE_BITS;
  localparam int LINKS       = POOL_BYTES >> 3;

  // Derived widths.
  localparam int SIDX_W = $clog2(SLICES);
  localparam int CNT_W  = $clog2(SLICES + 1);
  localparam int CLS_W  = $clog2(CLASSES);
  localparam int OFF_W  = SIDX_W + SLICE_BITS;
  localparam int FILL_W = SLICE_BITS + 1;
  localparam int LINK_W = $clog2(LINKS);

  localparam int ADDR_W = 64;
  localparam int SIZE_W = 32;
  localparam int STAT_W = 3;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_TOO_LARGE = 3'd1;
  localparam logic [STAT_W-1:0] ST_EXHAUSTED = 3'd2;
  localparam logic [STAT_W-1:0] ST_OUTSIDE   = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_CLASS = 3'd4;

  // Free-list head or link entry: a valid bit and a byte offset into the pool.
  typedef struct packed {
    logic             valid;
    logic [OFF_W-1:0] off;
  } link_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;
    logic              pop_start;
    logic              pop_finish;
    logic              carve;
    logic              next_class;
    logic              free_sub;
    logic              free_read;
    logic              push;
    logic              set_res;
    logic              res_ok;
    logic [STAT_W-1:0] res_status;
    logic              emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic too_large;
    logic head_valid;
    logic need_slice;
    logic pool_full;
    logic last_class;
    logic outside;
    logic bad_class;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/scba_ctrl.sv @@
`default_nettype none

module scba_ctrl
  import scba_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     mode_i,
  output logic          in_stall_o,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_ALLOC     = 3'd1;
  localparam logic [2:0] S_POP       = 3'd2;
  localparam logic [2:0] S_FREE_SUB  = 3'd3;
  localparam logic [2:0] S_FREE_RD   = 3'd4;
  localparam logic [2:0] S_FREE_PUSH = 3'd5;
  localparam logic [2:0] S_DONE      = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = mode_i ? S_FREE_SUB : S_ALLOC;
        end
      end
      S_ALLOC: begin
        priority if (stat_i.too_large) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = ST_TOO_LARGE;
          state_d          = S_DONE;
        end else if (stat_i.head_valid) begin
          cmd_o.pop_start = 1'b1;
          state_d         = S_POP;
        end else if (stat_i.need_slice && stat_i.pool_full) begin
          if (stat_i.last_class) begin
            cmd_o.set_res    = 1'b1;
            cmd_o.res_status = ST_EXHAUSTED;
            state_d          = S_DONE;
          end else begin
            cmd_o.next_class = 1'b1;
          end
        end else begin
          cmd_o.carve      = 1'b1;
          cmd_o.set_res    = 1'b1;
          cmd_o.res_ok     = 1'b1;
          cmd_o.res_status = ST_OK;
          state_d          = S_DONE;
        end
      end
      S_POP: begin
        cmd_o.pop_finish = 1'b1;
        cmd_o.set_res    = 1'b1;
        cmd_o.res_ok     = 1'b1;
        cmd_o.res_status = ST_OK;
        state_d          = S_DONE;
      end
      S_FREE_SUB: begin
        cmd_o.free_sub = 1'b1;
        state_d        = S_FREE_RD;
      end
      S_FREE_RD: begin
        if (stat_i.outside) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = ST_OUTSIDE;
          state_d          = S_DONE;
        end else begin
          cmd_o.free_read = 1'b1;
          state_d         = S_FREE_PUSH;
        end
      end
      S_FREE_PUSH: begin
        cmd_o.set_res = 1'b1;
        if (stat_i.bad_class) begin
          cmd_o.res_status = ST_BAD_CLASS;
        end else begin
          cmd_o.push       = 1'b1;
          cmd_o.res_status = ST_OK;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/scba_datapath.sv @@
`default_nettype none

module scba_datapath
  import scba_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [ADDR_W-1:0] cfg_wdata_i,
  input  wire logic [SIZE_W-1:0] request_size_i,
  input  wire logic [ADDR_W-1:0] block_address_i,
  input  wire dp_cmd_t           cmd_i,
  output dp_stat_t               stat_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [ADDR_W-1:0]      result_address_o,
  output logic [STAT_W-1:0]      status_o
);

  logic [ADDR_W-1:0] pool_base_q;

  // Per-class tables, read only at the class under work.
  logic              has_q   [CLASSES];
  logic [SIDX_W-1:0] start_q [CLASSES];
  logic [FILL_W-1:0] fill_q  [CLASSES];
  link_t             head_q  [CLASSES];
  logic [CNT_W-1:0]  claimed_q;

  // Memories.
  logic [CLS_W-1:0] owner_mem [SLICES];
  link_t            link_mem  [LINKS];
  logic [CLS_W-1:0] owner_rdata_q;
  link_t            link_rdata_q;

  // Request registers.
  logic [CLS_W-1:0]  k_q;
  logic              too_large_q;
  logic [ADDR_W-1:0] blk_q;
  logic [ADDR_W-1:0] off_q;
  logic              owner_hit_q;

  // Pending result and output register.
  logic              res_ok_q;
  logic [OFF_W-1:0]  res_off_q;
  logic [STAT_W-1:0] res_status_q;
  logic              out_valid_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic [STAT_W-1:0] out_status_q;

  // Size class of the incoming request: smallest class at least as big.
  logic [SIZE_W-1:0] size_eff;
  logic [CLASSES-1:0] fits;
  logic [CLS_W-1:0]  k_enc;

  always_comb begin
    size_eff = (request_size_i < SIZE_W'(8)) ? SIZE_W'(8) : request_size_i;
    for (int i = 0; i < CLASSES; i++) begin
      fits[i] = ({1'b0, size_eff} <= ((SIZE_W + 1)'(1) << i));
    end
    k_enc = '0;
    for (int i = CLASSES - 1; i >= 0; i--) begin
      if (fits[i]) begin
        k_enc = CLS_W'(i);
      end
    end
  end

  logic              need_slice;
  logic [OFF_W-1:0]  carve_off;
  logic [FILL_W-1:0] blk_bytes;
  logic [SIDX_W-1:0] free_idx;
  logic [CLS_W-1:0]  free_cls;
  logic              out_free;

  assign blk_bytes  = FILL_W'(1) << k_q;
  assign need_slice = !has_q[k_q] || (fill_q[k_q] >= FILL_W'(SLICE_BYTES));
  assign carve_off  = need_slice
                    ? {claimed_q[SIDX_W-1:0], SLICE_BITS'(0)}
                    : ({start_q[k_q], SLICE_BITS'(0)} + OFF_W'(fill_q[k_q]));
  assign free_idx   = off_q[SLICE_BITS +: SIDX_W];
  assign free_cls   = owner_hit_q ? owner_rdata_q : '0;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    stat_o            = '0;
    stat_o.too_large  = too_large_q;
    stat_o.head_valid = head_q[k_q].valid;
    stat_o.need_slice = need_slice;
    stat_o.pool_full  = (claimed_q >= CNT_W'(SLICES));
    stat_o.last_class = (k_q == CLS_W'(CLASSES - 1));
    stat_o.outside    = (off_q[ADDR_W-1:SLICE_BITS] >= (ADDR_W - SLICE_BITS)'(SLICES));
    stat_o.bad_class  = ({1'b0, free_cls} >= (CLS_W + 1)'(CLASSES));
    stat_o.out_free   = out_free;
  end

  // Request, offset and pending-result registers need no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      k_q         <= k_enc;
      too_large_q <= !fits[CLASSES-1];
      blk_q       <= block_address_i;
    end else if (cmd_i.next_class) begin
      k_q <= k_q + CLS_W'(1);
    end
    if (cmd_i.free_sub) begin
      off_q <= blk_q - pool_base_q;
    end
    if (cmd_i.free_read) begin
      owner_hit_q <= (CNT_W'(free_idx) < claimed_q);
    end
    if (cmd_i.pop_start) begin
      res_off_q <= head_q[k_q].off;
    end else if (cmd_i.carve) begin
      res_off_q <= carve_off;
    end
    if (cmd_i.set_res) begin
      res_ok_q     <= cmd_i.res_ok;
      res_status_q <= cmd_i.res_status;
    end
    if (cmd_i.emit) begin
      out_addr_q   <= res_ok_q ? (pool_base_q + ADDR_W'(res_off_q)) : '0;
      out_status_q <= res_status_q;
    end
  end

  // Owner class store: written when a slice is claimed, read on free.
  always_ff @(posedge clk_i) begin
    if (cmd_i.carve && need_slice) begin
      owner_mem[claimed_q[SIDX_W-1:0]] <= k_q;
    end
    if (cmd_i.free_read) begin
      owner_rdata_q <= owner_mem[free_idx];
    end
  end

  // Link store, one entry per 8-byte word of the pool.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      link_mem[off_q[OFF_W-1:3]] <= head_q[free_cls];
    end
    if (cmd_i.pop_start) begin
      link_rdata_q <= link_mem[head_q[k_q].off[OFF_W-1:3]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= '0;
      claimed_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CLASSES; i++) begin
        has_q[i]  <= 1'b0;
        start_q[i] <= '0;
        fill_q[i] <= '0;
        head_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        pool_base_q <= cfg_wdata_i;
      end
      if (cmd_i.carve) begin
        if (need_slice) begin
          start_q[k_q] <= claimed_q[SIDX_W-1:0];
          has_q[k_q]   <= 1'b1;
          fill_q[k_q]  <= blk_bytes;
          claimed_q    <= claimed_q + CNT_W'(1);
        end else begin
          fill_q[k_q] <= fill_q[k_q] + blk_bytes;
        end
      end
      if (cmd_i.pop_finish) begin
        head_q[k_q] <= link_rdata_q;
      end
      if (cmd_i.push) begin
        head_q[free_cls].valid <= 1'b1;
        head_q[free_cls].off   <= off_q[OFF_W-1:0];
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_address_o = out_addr_q;
  assign status_o         = out_status_q;

endmodule

`default_nettype wire

@@ rtl/size_class_block_allocator.sv @@
`default_nettype none

// Size-class block allocator over a pool of 64 slices of 1 KB that starts at
// the configured pool base. Each request either allocates a block (size raised
// to at least 8 bytes and rounded up to a power-of-two class of at most 512
// bytes) or frees one, and each request returns exactly one result with an
// address and a status. The block handles one request at a time. An allocate
// either carves a block from a slice or fails in its class check, or pops its
// class's free list through a registered read of the link store. When its
// class needs a slice and the pool has none left, it moves on to the next
// larger class, at most six times. A free subtracts the pool base, fails if
// the block lies outside the pool, else reads the slice owner store, then
// pushes the block onto its class's free list unless its class is bad. The
// input is taken again once the result is loaded. A result sits in an output
// register, so the block finishes the next request's work while that result
// waits; it then holds until the register is taken. No clearing pass is
// needed after reset.
module size_class_block_allocator
  import scba_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Configuration: pool base address.
  input  wire logic              cfg_we_i,
  input  wire logic [ADDR_W-1:0] cfg_wdata_i,
  // Request channel.
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              mode_i,
  input  wire logic [SIZE_W-1:0] request_size_i,
  input  wire logic [ADDR_W-1:0] block_address_i,
  // Result channel.
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [ADDR_W-1:0]      result_address_o,
  output logic [STAT_W-1:0]      status_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller sequences each request; the datapath owns all tables.
  scba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  scba_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .request_size_i   (request_size_i),
    .block_address_i  (block_address_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_address_o (result_address_o),
    .status_o         (status_o)
  );

endmodule

`default_nettype wire

@@ rtl/scba_checker.sv @@
`default_nettype none

module scba_checker
  import scba_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [ADDR_W-1:0] result_address_o,
  input wire logic [STAT_W-1:0] status_o
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_address_o)
                                   && $stable(status_o))
    else $error("stalled result changed");

  // Requests are taken one at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while another is in work");

  // Only defined status codes appear.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ST_BAD_CLASS)
    else $error("undefined status code");

  // A failed request never reports an address.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> result_address_o == '0)
    else $error("nonzero address on failure");

endmodule

bind size_class_block_allocator scba_checker u_scba_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .result_address_o (result_address_o),
  .status_o         (status_o)
);

`default_nettype wire
